[design/rrqg_pkg.sv]
// rrqg_pkg: shared types, register codes and constants for the round-robin queue grant block
// depends on nothing; used by every rrqg module
package rrqg_pkg;

    // fixed field widths
    localparam int unsigned LIMIT_REGS  = 4;
    localparam int unsigned LIMIT_W     = 7;
    localparam int unsigned QCOUNT_W    = 3;
    localparam int unsigned MASK_W      = 4;
    localparam int unsigned QSEL_W      = 2;
    localparam int unsigned REG_IDX_W   = 3;
    // compare width for queue numbers and counts (holds counts up to 15)
    localparam int unsigned CMP_W       = 4;

    // default parameter values
    localparam int unsigned DEF_QUEUES      = 4;
    localparam int unsigned DEF_MAX_WORKERS = 64;

    // item kinds
    typedef enum logic {
        FUNC_REQUEST  = 1'b0,
        FUNC_COMPLETE = 1'b1
    } t_func;

    // configuration register indexes
    typedef enum logic [REG_IDX_W-1:0] {
        REG_QUEUE_COUNT = 3'd0,
        REG_LIMIT_0     = 3'd1,
        REG_LIMIT_1     = 3'd2,
        REG_LIMIT_2     = 3'd3,
        REG_LIMIT_3     = 3'd4
    } t_reg_idx;

    // request / completion item
    typedef struct packed {
        logic                func;
        logic [MASK_W-1:0]   waiting_mask;
        logic [QSEL_W-1:0]   done_queue;
    } t_req;

    // result item
    typedef struct packed {
        logic                granted;
        logic [QSEL_W-1:0]   grant_queue;
        logic                underflow;
    } t_res;

    // configuration write
    typedef struct packed {
        logic [REG_IDX_W-1:0] index;
        logic [LIMIT_W-1:0]   value;
    } t_cfg_wr;

    // configuration register contents
    typedef struct packed {
        logic [QCOUNT_W-1:0]                 queue_count;
        logic [LIMIT_REGS-1:0][LIMIT_W-1:0]  limit;
    } t_cfg_regs;

endpackage

[design/rrqg_chan.sv]
// rrqg_chan: valid/ready channel carrying one payload type
// payload types come from rrqg_pkg
interface rrqg_chan #(
    parameter type t_data = logic
);
    logic  valid;
    logic  ready;
    t_data data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[design/round_robin_queue_grant_with_limits.sv]
// round_robin_queue_grant_with_limits: top level of the round-robin queue grant block
// depends on rrqg_pkg, rrqg_chan, rrqg_cfg_regs and rrqg_pick
//
//  channel  | direction | payload                               | transfer when
//  ---------+-----------+---------------------------------------+-------------------
//  i_req    | in        | func, waiting_mask, done_queue        | valid & ready
//  o_res    | out       | granted, grant_queue, underflow       | valid & ready
//  i_cfg    | in        | index, value                          | valid & ready
//
// each item goes from transfer to result through an input register, then the
// grant search and counter update into the result register
// one item per cycle unless o_res stalls; counters and pointer load with the result
// a stalled result holds the input register, and i_req.ready drops only when both are full
// synchronous active-low reset clears pointer, counters, config and valid flags
module round_robin_queue_grant_with_limits #(
    parameter int unsigned QUEUES      = rrqg_pkg::DEF_QUEUES,
    parameter int unsigned MAX_WORKERS = rrqg_pkg::DEF_MAX_WORKERS
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    rrqg_chan.sink   i_req,
    rrqg_chan.source o_res,
    rrqg_chan.sink   i_cfg
);

    localparam int unsigned PW    = $clog2(QUEUES);
    localparam int unsigned CW    = $clog2(MAX_WORKERS + 1);
    localparam int unsigned CMP_W = rrqg_pkg::CMP_W;

    rrqg_pkg::t_cfg_regs       cfg_regs;

    logic                      r_in_vld;
    rrqg_pkg::t_req            r_in;
    logic                      r_out_vld;
    rrqg_pkg::t_res            r_out;
    logic [PW-1:0]             r_ptr;
    logic [QUEUES-1:0][CW-1:0] r_in_flight;

    logic [QUEUES-1:0][CW-1:0] n_in_flight;
    logic [PW-1:0]             n_ptr;
    rrqg_pkg::t_res            n_out;

    logic                      advance;
    logic                      pick_hit;
    logic [PW-1:0]             pick_queue;
    logic [PW-1:0]             pick_next_ptr;
    logic                      done_ok;
    logic [PW-1:0]             done_idx;

    // configuration registers
    rrqg_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_regs  (cfg_regs)
    );

    // grant search
    rrqg_pick #(
        .QUEUES      (QUEUES),
        .MAX_WORKERS (MAX_WORKERS)
    ) u_pick (
        .i_regs         (cfg_regs),
        .i_waiting_mask (r_in.waiting_mask),
        .i_ptr          (r_ptr),
        .i_in_flight    (r_in_flight),
        .o_hit          (pick_hit),
        .o_queue        (pick_queue),
        .o_next_ptr     (pick_next_ptr)
    );

    // handshake: the stage moves when the result register is free or being drained
    assign advance     = r_in_vld && (!r_out_vld || o_res.ready);
    assign i_req.ready = !r_in_vld || advance;
    assign o_res.valid = r_out_vld;
    assign o_res.data  = r_out;

    assign done_ok  = CMP_W'(r_in.done_queue) < CMP_W'(QUEUES);
    assign done_idx = PW'(r_in.done_queue);

    // result and next state for the item in the input register
    always_comb begin
        n_in_flight = r_in_flight;
        n_ptr       = r_ptr;
        n_out       = '0;
        if (r_in.func == rrqg_pkg::FUNC_REQUEST) begin
            if (pick_hit) begin
                n_in_flight[pick_queue] = r_in_flight[pick_queue] + CW'(1);
                n_ptr                   = pick_next_ptr;
                n_out.granted           = 1'b1;
                n_out.grant_queue       = rrqg_pkg::QSEL_W'(pick_queue);
            end
        end else if (done_ok) begin
            if (r_in_flight[done_idx] == '0) begin
                n_out.underflow = 1'b1;
            end else begin
                n_in_flight[done_idx] = r_in_flight[done_idx] - CW'(1);
            end
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_req.ready) begin
            r_in_vld <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in <= i_req.data;
        end
    end

    // result register and state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld   <= 1'b0;
            r_ptr       <= '0;
            r_in_flight <= '0;
        end else begin
            if (advance) begin
                r_out_vld   <= 1'b1;
                r_ptr       <= n_ptr;
                r_in_flight <= n_in_flight;
            end else if (o_res.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    // pointer stays inside the queue range
    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMP_W'(r_ptr) < CMP_W'(QUEUES))
        else $error("round-robin pointer out of range");

    // a result is never both a grant and an underflow
    a_res_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> !(r_out.granted && r_out.underflow))
        else $error("result flags both grant and underflow");

    // counters and pointer only change when an item moves to the result register
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> ($stable(r_in_flight) && $stable(r_ptr)))
        else $error("state changed without an item");

    // no queue ever exceeds the worker bound
    for (genvar g = 0; g < QUEUES; g++) begin : g_bound
        a_flight_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            r_in_flight[g] <= CW'(MAX_WORKERS))
            else $error("in-flight count above worker bound");
    end

endmodule

[design/rrqg_cfg_regs.sv]
// rrqg_cfg_regs: queue count and per-queue limit registers behind the config channel
// depends on rrqg_pkg and rrqg_chan
module rrqg_cfg_regs (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    rrqg_chan.sink               i_cfg,
    output rrqg_pkg::t_cfg_regs  o_regs
);

    rrqg_pkg::t_cfg_regs r_regs;

    // config writes are always taken
    assign i_cfg.ready = 1'b1;
    assign o_regs      = r_regs;

    // register write decode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.data.index)
                rrqg_pkg::REG_QUEUE_COUNT: begin
                    r_regs.queue_count <= i_cfg.data.value[rrqg_pkg::QCOUNT_W-1:0];
                end
                rrqg_pkg::REG_LIMIT_0: begin
                    r_regs.limit[0] <= i_cfg.data.value;
                end
                rrqg_pkg::REG_LIMIT_1: begin
                    r_regs.limit[1] <= i_cfg.data.value;
                end
                rrqg_pkg::REG_LIMIT_2: begin
                    r_regs.limit[2] <= i_cfg.data.value;
                end
                rrqg_pkg::REG_LIMIT_3: begin
                    r_regs.limit[3] <= i_cfg.data.value;
                end
                default: begin
                end
            endcase
        end
    end

endmodule

[design/rrqg_pick.sv]
// rrqg_pick: rotating-priority search for the next queue to grant
// depends on rrqg_pkg; purely combinational
module rrqg_pick #(
    parameter int unsigned QUEUES      = rrqg_pkg::DEF_QUEUES,
    parameter int unsigned MAX_WORKERS = rrqg_pkg::DEF_MAX_WORKERS,
    localparam int unsigned PW         = $clog2(QUEUES),
    localparam int unsigned CW         = $clog2(MAX_WORKERS + 1)
) (
    input  rrqg_pkg::t_cfg_regs               i_regs,
    input  logic [rrqg_pkg::MASK_W-1:0]       i_waiting_mask,
    input  logic [PW-1:0]                     i_ptr,
    input  logic [QUEUES-1:0][CW-1:0]         i_in_flight,
    output logic                              o_hit,
    output logic [PW-1:0]                     o_queue,
    output logic [PW-1:0]                     o_next_ptr
);

    localparam int unsigned CMP_W = rrqg_pkg::CMP_W;
    localparam int unsigned LW    = rrqg_pkg::LIMIT_W;

    logic [CMP_W-1:0]  cnt;
    logic [CMP_W-1:0]  start;
    logic [QUEUES-1:0] waiting;
    logic [QUEUES-1:0] elig;
    logic [QUEUES-1:0] elig_hi;
    logic [CMP_W-1:0]  q_inc;

    // active count, clamped to the number of queues
    always_comb begin
        if (CMP_W'(i_regs.queue_count) > CMP_W'(QUEUES)) begin
            cnt = CMP_W'(QUEUES);
        end else begin
            cnt = CMP_W'(i_regs.queue_count);
        end
    end

    // start position: pointer reduced modulo the active count
    always_comb begin
        start = CMP_W'(i_ptr);
        for (int k = 0; k < QUEUES - 1; k++) begin
            if (cnt != '0 && start >= cnt) begin
                start = start - cnt;
            end
        end
    end

    // only the first four queues can report waiting work
    assign waiting = QUEUES'(i_waiting_mask);

    // per-queue eligibility: active, waiting and under the limit
    always_comb begin
        logic [LW-1:0] lim;
        for (int q = 0; q < QUEUES; q++) begin
            lim = '0;
            if (q < rrqg_pkg::LIMIT_REGS) begin
                lim = i_regs.limit[q % rrqg_pkg::LIMIT_REGS];
            end
            if (lim == '0 || lim > LW'(MAX_WORKERS)) begin
                lim = LW'(MAX_WORKERS);
            end
            elig[q]    = (CMP_W'(q) < cnt) && waiting[q] && (LW'(i_in_flight[q]) < lim);
            elig_hi[q] = elig[q] && (CMP_W'(q) >= start);
        end
    end

    // lowest eligible queue at or after start, else lowest overall
    always_comb begin
        o_hit   = |elig;
        o_queue = '0;
        for (int q = QUEUES - 1; q >= 0; q--) begin
            if (elig[q]) begin
                o_queue = PW'(q);
            end
        end
        for (int q = QUEUES - 1; q >= 0; q--) begin
            if (elig_hi[q]) begin
                o_queue = PW'(q);
            end
        end
    end

    // pointer moves past the granted queue, wrapping at the active count
    assign q_inc = CMP_W'(o_queue) + CMP_W'(1);
    assign o_next_ptr = (q_inc == cnt) ? '0 : PW'(q_inc);

endmodule
